// ===== rtl/box_mean_filter_rgb_core_defines.svh =====
// Assertion macros shared by the box mean filter RTL.
// Depends on nothing; included by the top level only.
`ifndef BOX_MEAN_FILTER_RGB_CORE_DEFINES_SVH
`define BOX_MEAN_FILTER_RGB_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BMF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define BMF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmf_pkg.sv =====
// Shared types and constants for the box mean filter core.
// No dependencies; imported by box_mean_filter_rgb_core.
package bmf_pkg;

    localparam int POS_W   = 9;
    localparam int COORD_W = 10;
    localparam int DIM_W   = 10;
    localparam int FILT_W  = 6;
    localparam int HALF_W  = 5;
    localparam int CHAN_W  = 8;
    localparam int COLORS  = 3;
    localparam int PIX_W   = CHAN_W * COLORS;
    // Largest window is 63 x 63 pixels.
    localparam int CNT_W   = 12;
    localparam int SUM_W   = 20;
    localparam int QBIT_W  = 3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_WIDTH = 2'd2;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 10'd512;
    localparam logic [FILT_W-1:0] RST_FILTER_WIDTH = 6'd11;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } bmf_state_t;

endpackage

// ===== rtl/bmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the frame store.
module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/box_mean_filter_rgb_core.sv =====
// Box mean filter core: an RGB frame store with a box-mean read-out.
// Depends on bmf_pkg, bmf_ram and box_mean_filter_rgb_core_defines.svh.
//
// A write beat (cmd 0) stores one 24-bit pixel at (pos_x, pos_y) when it lies
// inside the store; writes can stream every cycle while no query is in flight
// and produce no result. A query beat (cmd 1) walks the clipped square window
// of side 2*(d/2)+1 around the pixel, reading one stored pixel per cycle from
// the single-read-port frame RAM. A query passes through the accept cycle, one
// read per in-image window pixel, a drain state for the last read to return, a
// radix-2 restoring divide over the eight quotient bits (one quotient bit per
// cycle, all three channels in parallel) and a done state that hands the result
// to the output register. A query outside the image returns zeros with
// out_of_image set. The result sits in an output register, so the next beat is
// taken while a result still waits for m_ready. Configure image_width (0x0),
// image_height (0x4) and filter_width (0x8) only while the core is idle; every
// image pixel must be written before it is covered by a query window.
`include "box_mean_filter_rgb_core_defines.svh"

module box_mean_filter_rgb_core #(
    parameter int MAX_W      = 512,
    parameter int MAX_H      = 512,
    parameter int MAX_FILTER = 63
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmf_pkg::PADDR_W-1:0]   paddr,
    input  logic [bmf_pkg::PDATA_W-1:0]   pwdata,
    output logic [bmf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [bmf_pkg::POS_W-1:0]     s_pos_x,
    input  logic [bmf_pkg::POS_W-1:0]     s_pos_y,
    input  logic [bmf_pkg::CHAN_W-1:0]    s_in_red,
    input  logic [bmf_pkg::CHAN_W-1:0]    s_in_green,
    input  logic [bmf_pkg::CHAN_W-1:0]    s_in_blue,
    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bmf_pkg::CHAN_W-1:0]    m_mean_red,
    output logic [bmf_pkg::CHAN_W-1:0]    m_mean_green,
    output logic [bmf_pkg::CHAN_W-1:0]    m_mean_blue,
    output logic                          m_out_of_image
);

    import bmf_pkg::*;

    localparam int DEPTH  = MAX_W * MAX_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Row-major frame address: y * MAX_W + x (a multiply by a constant).
    function automatic logic [ADDR_W-1:0] frame_addr(input coord_t x, input coord_t y);
        logic [31:0] full;
        full = 32'(y) * 32'(MAX_W) + 32'(x);
        return full[ADDR_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;
    logic [FILT_W-1:0] filter_width_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            filter_width_reg <= RST_FILTER_WIDTH;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_FILTER_WIDTH: filter_width_reg <= pwdata[FILT_W-1:0];
                default: ; // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_reg);
            REG_FILTER_WIDTH: prdata = PDATA_W'(filter_width_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective image size and window half size: clamp to the store limits.
    coord_t            img_w;
    coord_t            img_h;
    logic [FILT_W-1:0] filt_eff;
    coord_t            half;

    assign img_w    = (32'(image_width_reg) > 32'(MAX_W)) ? COORD_W'(MAX_W) : image_width_reg;
    assign img_h    = (32'(image_height_reg) > 32'(MAX_H)) ? COORD_W'(MAX_H) : image_height_reg;
    assign filt_eff = (32'(filter_width_reg) > 32'(MAX_FILTER)) ?
                      FILT_W'(MAX_FILTER) : filter_width_reg;
    assign half     = COORD_W'(filt_eff[FILT_W-1:1]);

    // ---------------------------------------------------------------
    // Input decode and window bounds (computed at the accept edge)
    // ---------------------------------------------------------------
    coord_t px;
    coord_t py;
    coord_t px_end;
    coord_t py_end;
    coord_t win_x0;
    coord_t win_y0;
    coord_t win_x1;
    coord_t win_y1;
    logic   q_outside;
    logic   in_accept;
    logic   take_query;
    logic   take_write;
    logic   wr_in_store;

    assign px        = COORD_W'(s_pos_x);
    assign py        = COORD_W'(s_pos_y);
    assign px_end    = px + half;
    assign py_end    = py + half;
    assign win_x0    = (px >= half) ? (px - half) : '0;
    assign win_y0    = (py >= half) ? (py - half) : '0;
    assign win_x1    = (px_end < img_w) ? px_end : (img_w - 1'b1);
    assign win_y1    = (py_end < img_h) ? py_end : (img_h - 1'b1);
    assign q_outside = (px >= img_w) || (py >= img_h);

    assign in_accept   = s_valid & s_ready;
    assign take_query  = in_accept & (s_cmd == CMD_QUERY);
    assign take_write  = in_accept & (s_cmd == CMD_WRITE);
    assign wr_in_store = (32'(s_pos_x) < 32'(MAX_W)) && (32'(s_pos_y) < 32'(MAX_H));

    // ---------------------------------------------------------------
    // Frame store
    // ---------------------------------------------------------------
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    bmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (frame_addr(px, py)),
        .wdata ({s_in_blue, s_in_green, s_in_red}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer state and datapath registers
    // ---------------------------------------------------------------
    bmf_state_t state_reg, state_next;

    coord_t               cx_reg, cx_next;
    coord_t               cy_reg, cy_next;
    coord_t               x0_reg, x0_next;
    coord_t               x1_reg, x1_next;
    coord_t               y1_reg, y1_next;
    logic                 rd_pending_reg, rd_pending_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    sum_t                 sum_reg  [COLORS];
    sum_t                 sum_next [COLORS];
    chan_t                quo_reg  [COLORS];
    chan_t                quo_next [COLORS];
    logic [QBIT_W-1:0]    step_reg, step_next;
    logic                 err_reg, err_next;

    logic                 m_valid_reg, m_valid_next;
    chan_t                m_mean_reg [COLORS];
    logic                 m_oob_reg;

    logic                 scan_row_end;
    logic                 scan_last;
    logic                 out_load;
    sum_t                 trial;

    assign scan_row_end = (cx_reg == x1_reg);
    assign scan_last    = scan_row_end && (cy_reg == y1_reg);
    assign trial        = SUM_W'(cnt_reg) << step_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_query) begin
                    state_next = q_outside ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        ram_re    = (state_reg == ST_SCAN);
        ram_raddr = frame_addr(cx_reg, cy_reg);
        out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    // Writes go straight to the store at the accept edge.
    assign ram_we = take_write & wr_in_store;

    // Datapath next values
    always_comb begin
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        err_next        = err_reg;
        rd_pending_next = (state_reg == ST_SCAN);
        for (int c = 0; c < COLORS; c++) begin
            sum_next[c] = sum_reg[c];
            quo_next[c] = quo_reg[c];
        end

        if (take_query) begin
            // Load the window walk and clear the accumulators.
            cx_next  = win_x0;
            cy_next  = win_y0;
            x0_next  = win_x0;
            x1_next  = win_x1;
            y1_next  = win_y1;
            cnt_next = '0;
            err_next = q_outside;
            for (int c = 0; c < COLORS; c++) begin
                sum_next[c] = '0;
                quo_next[c] = '0;
            end
        end

        if (state_reg == ST_SCAN) begin
            // Advance across the row, then wrap to the next row.
            if (scan_row_end) begin
                cx_next = x0_reg;
                cy_next = cy_reg + 1'b1;
            end else begin
                cx_next = cx_reg + 1'b1;
            end
        end

        if (rd_pending_reg) begin
            // Accumulate the pixel that the previous cycle read.
            cnt_next = cnt_reg + 1'b1;
            for (int c = 0; c < COLORS; c++) begin
                sum_next[c] = sum_reg[c] + SUM_W'(ram_rdata[c*CHAN_W +: CHAN_W]);
            end
        end

        if (state_reg == ST_DRAIN) begin
            step_next = '1;
        end

        if (state_reg == ST_DIV) begin
            // One restoring step per cycle; the remainder lives in the sum.
            step_next = step_reg - 1'b1;
            for (int c = 0; c < COLORS; c++) begin
                if (sum_reg[c] >= trial) begin
                    sum_next[c] = sum_reg[c] - trial;
                    quo_next[c] = {quo_reg[c][CHAN_W-2:0], 1'b1};
                end else begin
                    quo_next[c] = {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        cnt_reg  <= cnt_next;
        step_reg <= step_next;
        err_reg  <= err_next;
        for (int c = 0; c < COLORS; c++) begin
            sum_reg[c] <= sum_next[c];
            quo_reg[c] <= quo_next[c];
        end
        if (out_load) begin
            m_oob_reg <= err_reg;
            for (int c = 0; c < COLORS; c++) begin
                m_mean_reg[c] <= quo_reg[c];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mean_red     = m_mean_reg[0];
    assign m_mean_green   = m_mean_reg[1];
    assign m_mean_blue    = m_mean_reg[2];
    assign m_out_of_image = m_oob_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BMF_ASSERT_IMP(a_no_write_in_query, aclk, aresetn, (state_reg != ST_IDLE), !ram_we, "frame write while a query is in flight")
    `BMF_ASSERT_IMP(a_read_from_scan, aclk, aresetn, rd_pending_reg, ($past(state_reg) == ST_SCAN), "read data expected without a scan read")
    `BMF_ASSERT_IMP(a_div_nonzero, aclk, aresetn, (state_reg == ST_DIV), (cnt_reg != '0), "divide started with an empty window")
    `BMF_ASSERT_NXT(a_oob_zero, aclk, aresetn, (out_load && err_reg), (m_mean_red == '0 && m_mean_green == '0 && m_mean_blue == '0), "out-of-image result carries nonzero means")

endmodule
